// ===== src/magnetometer_hard_iron_calibrator_defines.svh =====
// ----------------------------------------------------------------------------
// Magnetometer hard-iron calibrator assertion macros
// Concurrent check wrappers; defining ASSERT_OFF compiles them out.
// ----------------------------------------------------------------------------
`ifndef MAGNETOMETER_HARD_IRON_CALIBRATOR_DEFINES_SVH
`define MAGNETOMETER_HARD_IRON_CALIBRATOR_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication under an active-low reset
`define HIC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hic: implication check failed");

// Next-cycle implication under an active-low reset
`define HIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hic: next-cycle check failed");

`else

`define HIC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define HIC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/hic_pkg.sv =====
// ----------------------------------------------------------------------------
// Hard-iron calibrator package
// Widths, sample types and the axis assembly function shared by the block.
// ----------------------------------------------------------------------------
package hic_pkg;

    localparam int BYTE_W           = 8;
    localparam int AXIS_W           = 16;
    localparam int CORR_W           = 17;
    localparam int IN_TDATA_W       = 56;
    localparam int OUT_TDATA_W      = 56;
    localparam int STATUS_READY_BIT = 0;

    typedef logic [BYTE_W-1:0]        t_byte;
    typedef logic signed [AXIS_W-1:0] t_sample;
    typedef logic signed [CORR_W-1:0] t_corr;

    // Join high and low bytes into a two's complement axis sample
    function automatic t_sample assemble_axis(input t_byte lo, input t_byte hi);
        assemble_axis = t_sample'({hi, lo});
    endfunction

endpackage

// ===== src/hic_axis.sv =====
// ----------------------------------------------------------------------------
// Hard-iron calibrator, one axis
// Holds the axis minimum and maximum, updates them while tracking, and
// forms the sample minus the truncated midpoint of the two.
// ----------------------------------------------------------------------------
module hic_axis
    import hic_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_sample i_sample,
    input  logic    i_track,
    output t_corr   o_corrected
);

    t_sample r_min;
    t_sample r_max;
    t_sample n_min;
    t_sample n_max;

    logic signed [CORR_W-1:0] w_sum;
    logic signed [CORR_W-1:0] w_mid;

    // Minimum first; a zero extreme counts as unset
    always_comb begin
        n_min = r_min;
        n_max = r_max;
        if (i_sample < r_min || r_min == '0) begin
            n_min = i_sample;
        end else if (i_sample > r_max || r_max == '0) begin
            n_max = i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '0;
            r_max <= '0;
        end else if (i_track) begin
            r_min <= n_min;
            r_max <= n_max;
        end
    end

    // Midpoint truncated toward zero: bias odd negative sums up before the shift
    assign w_sum = {r_min[AXIS_W-1], r_min} + {r_max[AXIS_W-1], r_max};
    assign w_mid = $signed(w_sum + {{(CORR_W-1){1'b0}}, w_sum[CORR_W-1]}) >>> 1;

    assign o_corrected = {i_sample[AXIS_W-1], i_sample} - w_mid;

endmodule

// ===== src/magnetometer_hard_iron_calibrator.sv =====
// ----------------------------------------------------------------------------
// Magnetometer hard-iron calibrator
// One sensor read enters per request on the s_axis channel. Reads whose
// status bit 0 is clear are dropped. With calibrate_mode set (cfg channel)
// the per-axis minimum and maximum are tracked and nothing is sent; with it
// clear each read leaves on m_axis as three offset-corrected axes.
// A request passes the input register, then the result register, to m_axis.
// Throughput: one request per cycle unless m_axis stalls; both registers set
// it, with the per-axis compares, adds and subtract between them. Reset
// zeroes the mode, both stage valids and all extremes. On a receiver stall the
// result register holds its request, the input register takes reads until it
// holds one to send, and s_axis_tready drops until m_axis_tready returns.
// Config writes are always ready and unchecked; the user must make them idle.
// ----------------------------------------------------------------------------
`include "magnetometer_hard_iron_calibrator_defines.svh"

module magnetometer_hard_iron_calibrator
    import hic_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // tdata: status_byte, x_low_byte, x_high_byte, y_low_byte, y_high_byte,
    //        z_low_byte, z_high_byte
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tdata: x_corrected, y_corrected, z_corrected, 5 zero pad bits
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // data: calibrate_mode
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_cfg_data
);

    logic                   r_cal_mode;
    logic                   r_in_valid;
    logic [IN_TDATA_W-1:0]  r_in_data;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [OUT_TDATA_W-1:0] n_out_data;

    t_sample w_x;
    t_sample w_y;
    t_sample w_z;
    t_corr   w_x_corr;
    t_corr   w_y_corr;
    t_corr   w_z_corr;
    logic    w_data_ready;
    logic    w_emit;
    logic    w_track;
    logic    w_out_free;
    logic    w_advance;

    // Configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_cal_mode <= i_cfg_data;
        end
    end

    // Decode the registered read
    assign w_x = assemble_axis(r_in_data[15:8],  r_in_data[23:16]);
    assign w_y = assemble_axis(r_in_data[31:24], r_in_data[39:32]);
    assign w_z = assemble_axis(r_in_data[47:40], r_in_data[55:48]);

    assign w_data_ready = r_in_data[STATUS_READY_BIT];
    assign w_emit       = r_in_valid && w_data_ready && !r_cal_mode;
    assign w_track      = r_in_valid && w_data_ready && r_cal_mode;
    assign w_out_free   = !r_out_valid || m_axis_tready;
    assign w_advance    = !w_emit || w_out_free;

    assign s_axis_tready = w_advance;

    // Input register: advance unless a result is stuck behind a stalled output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_advance) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && s_axis_tvalid) begin
            r_in_data <= s_axis_tdata;
        end
    end

    // Per-axis extremes and correction
    hic_axis u_axis_x (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (w_x),
        .i_track     (w_track),
        .o_corrected (w_x_corr)
    );

    hic_axis u_axis_y (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (w_y),
        .i_track     (w_track),
        .o_corrected (w_y_corr)
    );

    hic_axis u_axis_z (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (w_z),
        .i_track     (w_track),
        .o_corrected (w_z_corr)
    );

    // Pack the result, zero padded to whole bytes
    assign n_out_data = {{(OUT_TDATA_W - 3*CORR_W){1'b0}}, w_z_corr, w_y_corr, w_x_corr};

    // Result register: load on emit, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit && w_out_free) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Checks
    `HIC_ASSERT_NEXT(a_cal_no_result, i_clk, i_rst_n, r_cal_mode && !m_axis_tvalid, !m_axis_tvalid)
    `HIC_ASSERT_IMPLY(a_stall_cause, i_clk, i_rst_n, !s_axis_tready, r_in_valid && m_axis_tvalid && !m_axis_tready)
    `HIC_ASSERT_IMPLY(a_result_source, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(r_in_valid))

endmodule

// ===== dv/magnetometer_hard_iron_calibrator_tb.sv =====
// ----------------------------------------------------------------------------
// Magnetometer hard-iron calibrator testbench
// Streams sensor reads into the calibrator in tracking and correcting modes.
// A local copy of the per-axis extremes predicts every corrected sample. Each
// result is compared axis by axis, in order. Both stream sides idle at
// random, and the output side also holds off for long stretches.
// ----------------------------------------------------------------------------
module magnetometer_hard_iron_calibrator_tb;
    import hic_pkg::*;

    localparam logic MODE_CORRECT   = 1'b0;
    localparam logic MODE_TRACK     = 1'b1;
    localparam int   AXES           = 3;
    localparam int   PIPE_DRAIN     = 4;
    localparam int   WATCHDOG_LIMIT = 5000;
    localparam int   HOLD_OFF_LEN   = 40;

    typedef struct packed {
        t_corr x;
        t_corr y;
        t_corr z;
    } t_corrected;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // tdata: status_byte, x_low_byte, x_high_byte, y_low_byte, y_high_byte,
    //        z_low_byte, z_high_byte
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // tdata: x_corrected, y_corrected, z_corrected, zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic                   i_cfg_data    = 1'b0;

    // Local copy of calibrator state
    t_sample    axis_min [AXES];
    t_sample    axis_max [AXES];
    logic       track_mode;
    t_corrected corrected_q [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_left = 0;
    int stall_cycles  = 0;
    int mismatches    = 0;
    int reads_sent    = 0;
    int reads_dropped = 0;
    int reads_tracked = 0;
    int results_seen  = 0;

    magnetometer_hard_iron_calibrator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Apply one accepted read to the local state and queue its result
    task automatic apply_read(input t_byte status, input t_sample x, input t_sample y,
                              input t_sample z);
        t_sample    s [AXES];
        t_corr      c [AXES];
        int         mid;
        t_corrected res;
        s[0] = x;
        s[1] = y;
        s[2] = z;
        if (!status[STATUS_READY_BIT]) begin
            reads_dropped++;
            return;
        end
        if (track_mode) begin
            reads_tracked++;
            for (int a = 0; a < AXES; a++) begin
                if (s[a] < axis_min[a] || axis_min[a] == 0) begin
                    axis_min[a] = s[a];
                end else if (s[a] > axis_max[a] || axis_max[a] == 0) begin
                    axis_max[a] = s[a];
                end
            end
            return;
        end
        // Midpoint truncates toward zero, as int division does
        for (int a = 0; a < AXES; a++) begin
            mid  = (int'(axis_min[a]) + int'(axis_max[a])) / 2;
            c[a] = t_corr'(int'(s[a]) - mid);
        end
        res.x = c[0];
        res.y = c[1];
        res.z = c[2];
        corrected_q.push_back(res);
    endtask

    // Offer one read after a random gap and hold it until accepted
    task automatic send_read(input t_byte status, input t_sample x, input t_sample y,
                             input t_sample z);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x, status};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        reads_sent++;
        apply_read(status, x, y, z);
    endtask

    // Drop valid and wait until every queued result is back and the pipe is empty
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (corrected_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic mode);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        track_mode = mode;
    endtask

    task automatic set_idling(input int profile);
        case (profile)
            0: begin
                send_idle_pct = 29;
                recv_idle_pct = 60;
            end
            1: begin
                send_idle_pct = 60;
                recv_idle_pct = 29;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    function automatic t_byte random_status(input int ready_pct);
        t_byte st;
        st = t_byte'($urandom_range(255));
        st[STATUS_READY_BIT] = ($urandom_range(99) < ready_pct);
        return st;
    endfunction

    // Sample centered on zero within 2**span_log values, with some zeros
    function automatic t_sample span_sample(input int span_log);
        int r;
        if ($urandom_range(19) == 0) return '0;
        r = $urandom_range((1 << span_log) - 1);
        return t_sample'(r - (1 << (span_log - 1)));
    endfunction

    // Full-range sample, leaning on the corners
    function automatic t_sample wide_sample();
        case ($urandom_range(19))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return t_sample'($urandom_range(16'hFFFF));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH result %0d: %s", results_seen, msg);
        mismatches++;
    endtask

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_corrected got;
        t_corrected want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.x = m_axis_tdata[CORR_W-1:0];
            got.y = m_axis_tdata[2*CORR_W-1:CORR_W];
            got.z = m_axis_tdata[3*CORR_W-1:2*CORR_W];
            if (corrected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result x %0d y %0d z %0d",
                                          got.x, got.y, got.z));
            end else begin
                want = corrected_q.pop_front();
                if (got.x !== want.x) begin
                    report_mismatch($sformatf("x got %0d expected %0d", got.x, want.x));
                end
                if (got.y !== want.y) begin
                    report_mismatch($sformatf("y got %0d expected %0d", got.y, want.y));
                end
                if (got.z !== want.z) begin
                    report_mismatch($sformatf("z got %0d expected %0d", got.z, want.z));
                end
            end
            results_seen++;
        end
    end

    // Receiver: long hold-off when requested, else random stalls
    always @(posedge i_clk) begin
        if (hold_off_left > 0) begin
            hold_off_left <= hold_off_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: %0d results still expected", corrected_q.size());
            $display("end of test: mismatches");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Correcting with untouched extremes: midpoint zero, output equals sample
    task automatic test_uncalibrated();
        set_idling(2);
        send_read(8'h01, 16'sh0000, 16'sh7FFF, 16'sh8000);
        send_read(8'hFF, 16'shFFFF, 16'sh8000, 16'sh7FFF);
        send_read(8'hFE, 16'sh1234, 16'sh5678, 16'sh9ABC);
        send_read(8'h00, 16'shFFFF, 16'shFFFF, 16'shFFFF);
        send_read(8'h81, 16'sh00FF, 16'shFF00, 16'sh0100);
        wait_drain();
    endtask

    // Unset zeros, minimum before maximum, odd sums on both signs
    task automatic test_tracking_rules();
        write_mode(MODE_TRACK);
        send_read(8'h02, 16'sh4000, 16'shC000, 16'sh7FFF);
        send_read(8'h01, 16'sd0, 16'sd0, 16'sd0);
        send_read(8'h01, 16'sd100, -16'sd50, 16'sd20);
        send_read(8'h03, 16'sd151, -16'sd40, 16'sd10);
        send_read(8'h01, 16'sd120, -16'sd60, 16'sd30);
        send_read(8'hFD, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_read(8'h01, 16'sd50, 16'sd0, 16'sd30);
        send_read(8'h01, 16'sd60, -16'sd11, 16'sd25);
        wait_drain();
        write_mode(MODE_CORRECT);
        send_read(8'h01, 16'sd0, 16'sd0, 16'sd0);
        send_read(8'h01, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_read(8'h01, 16'sh8000, 16'sh8000, 16'sh8000);
        send_read(8'h55, 16'sd55, -16'sd35, 16'sd20);
        send_read(8'hAA, 16'sd1, 16'sd1, 16'sd1);
        wait_drain();
    endtask

    // Output held off while reads keep coming, then the sender waits it out
    task automatic test_backpressure();
        set_idling(2);
        hold_off_left = HOLD_OFF_LEN;
        for (int i = 0; i < 12; i++) begin
            send_read(random_status(100), wide_sample(), wide_sample(), wide_sample());
        end
        wait_drain();
    endtask

    // Track with a growing span, then correct full-range reads
    task automatic test_random_phases();
        for (int p = 0; p < 6; p++) begin
            set_idling(p % 3);
            write_mode(MODE_TRACK);
            for (int i = 0; i < 40; i++) begin
                send_read(random_status(85), span_sample(6 + 2 * p), span_sample(6 + 2 * p),
                          span_sample(6 + 2 * p));
            end
            wait_drain();
            write_mode(MODE_CORRECT);
            for (int i = 0; i < 100; i++) begin
                send_read(random_status(85), wide_sample(), wide_sample(), wide_sample());
            end
            wait_drain();
        end
    endtask

    initial begin
        for (int a = 0; a < AXES; a++) begin
            axis_min[a] = '0;
            axis_max[a] = '0;
        end
        track_mode = MODE_CORRECT;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_uncalibrated();
        test_tracking_rules();
        test_backpressure();
        test_random_phases();

        $display("covered %0d reads: %0d dropped as not ready, %0d tracked, %0d results",
                 reads_sent, reads_dropped, reads_tracked, results_seen);
        $display("final extremes x %0d..%0d y %0d..%0d z %0d..%0d", axis_min[0],
                 axis_max[0], axis_min[1], axis_max[1], axis_min[2], axis_max[2]);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
